[design/cidr_allowlist_match_core_defines.svh]
// Assertion macros for the CIDR allow-list match core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CIDR_ALLOWLIST_MATCH_CORE_DEFINES_SVH
`define CIDR_ALLOWLIST_MATCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset
`define CAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cal assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define CAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cal assertion failed");

`else

`define CAL_ASSERT_SAME(label, ante, cons)
`define CAL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/cal_pkg.sv]
// Shared types, codes and helpers for the CIDR allow-list match core.
// No dependencies; used by the interfaces, the cells, the register block and the top.
package cal_pkg;

    typedef logic [1:0]  cal_kind_t;
    typedef logic [31:0] cal_addr_t;
    typedef logic [5:0]  cal_plen_t;

    // Item kinds
    localparam cal_kind_t KIND_ADD   = 2'd0;
    localparam cal_kind_t KIND_CHECK = 2'd1;
    localparam cal_kind_t KIND_CLEAR = 2'd2;

    // Longest legal prefix
    localparam cal_plen_t PLEN_MAX = 6'd32;

    // Configuration port
    localparam int unsigned CAL_ADDR_W = 3;
    localparam int unsigned CAL_DATA_W = 32;
    localparam logic        CAL_REG_ALLOW_ALL = 1'b0;

    // Beat handed from cell to cell
    typedef struct packed {
        logic      chk;
        logic      hit;
        logic      drop;
        cal_addr_t addr;
    } cal_beat_t;

    // Entry write broadcast to the cells
    typedef struct packed {
        cal_addr_t network;
        cal_addr_t mask;
    } cal_wr_t;

    // Netmask for a prefix length of 0..32; zero length gives an all-zero mask
    function automatic cal_addr_t prefix_mask(input cal_plen_t len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

[design/cal_if.sv]
// Valid/ready channel interfaces for the CIDR allow-list match core.
// Depends on cal_pkg for the payload types.
interface cal_in_if import cal_pkg::*; ();
    logic      valid;
    logic      ready;
    cal_kind_t kind;
    cal_addr_t address;
    cal_plen_t prefix_length;

    modport source (output valid, kind, address, prefix_length, input ready);
    modport sink   (input valid, kind, address, prefix_length, output ready);
endinterface

interface cal_out_if import cal_pkg::*; ();
    logic valid;
    logic ready;
    logic allowed;
    logic dropped;

    modport source (output valid, allowed, dropped, input ready);
    modport sink   (input valid, allowed, dropped, output ready);
endinterface

[design/cal_cell.sv]
// One table cell: holds one prefix entry and registers the passing beat.
// Depends on cal_pkg.
module cal_cell import cal_pkg::*; #(
    parameter int unsigned CNT_W = 11,
    parameter int unsigned IDX   = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             wr_en,
    input  cal_wr_t          wr,
    input  logic             valid_in,
    input  cal_beat_t        beat_in,
    input  logic [CNT_W-1:0] limit_in,
    output logic             valid_out,
    output cal_beat_t        beat_out,
    output logic [CNT_W-1:0] limit_out
);

    cal_addr_t        net_reg;
    cal_addr_t        mask_reg;
    logic             valid_reg;
    cal_beat_t        beat_reg;
    cal_beat_t        beat_next;
    logic [CNT_W-1:0] limit_reg;
    logic             live;
    logic             match;

    // Entry counts only if it was in the table when the beat was taken
    assign live  = limit_in > CNT_W'(IDX);
    assign match = (beat_in.addr & mask_reg) == net_reg;

    always_comb
    begin
        beat_next     = beat_in;
        beat_next.hit = beat_in.hit | (beat_in.chk & live & match);
    end

    // Beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Beat payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg  <= beat_next;
            limit_reg <= limit_in;
        end
    end

    // Stored entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            net_reg  <= wr.network;
            mask_reg <= wr.mask;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;
    assign limit_out = limit_reg;

endmodule

[design/cal_apb_regs.sv]
// APB register block for the CIDR allow-list match core (allow_all only).
// Depends on cal_pkg.
module cal_apb_regs import cal_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CAL_ADDR_W-1:0] paddr,
    input  logic [CAL_DATA_W-1:0] pwdata,
    output logic [CAL_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  allow_all
);

    logic allow_all_reg;
    logic allow_all_next;
    logic wr_access;
    logic reg_idx;

    assign pready    = 1'b1;
    assign wr_access = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[2];

    // Write decode
    always_comb
    begin
        allow_all_next = allow_all_reg;
        if (wr_access)
        begin
            unique case (reg_idx)
                CAL_REG_ALLOW_ALL: allow_all_next = pwdata[0];
                default: ;
            endcase
        end
    end

    // Read decode
    always_comb
    begin
        unique case (reg_idx)
            CAL_REG_ALLOW_ALL: prdata = {{(CAL_DATA_W-1){1'b0}}, allow_all_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_all_reg <= 1'b0;
        end
        else
        begin
            allow_all_reg <= allow_all_next;
        end
    end

    assign allow_all = allow_all_reg;

endmodule

[design/cidr_allowlist_match_core.sv]
// CIDR allow-list match core.
// Channels: item (sink) carries kind, address and prefix_length; result (source) carries
// allowed and dropped, exactly one result beat per item beat, in item order.
// An add stores the masked prefix in the next free slot, or flags dropped when the table
// is full; a length above 32 stores nothing. A check reports allowed on a match with any
// stored prefix or when allow_all is set. A clear empties the table.
// The table is a chain of MAX_ENTRIES cells, one entry each. While result is not stalled,
// every beat walks the chain one cell per cycle and a new item is taken every cycle, for a
// throughput of one item per cycle. Table updates take effect at accept; each beat carries
// the entry count seen at accept so later adds never hit it. When result is stalled the
// whole chain holds and item.ready drops until the last beat is taken. Reset empties the
// pipe, zeroes the entry count and clears allow_all; stored entries are not cleared and
// need no sweep, so items are accepted right after reset. allow_all is written over APB at
// byte address 0; the user writes it only while the block is idle, which is not checked.
// Depends on cal_pkg, cal_if, cal_cell, cal_apb_regs and the defines header.
`include "cidr_allowlist_match_core_defines.svh"

module cidr_allowlist_match_core import cal_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cal_in_if.sink                item,
    cal_out_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CAL_ADDR_W-1:0] paddr,
    input  logic [CAL_DATA_W-1:0] pwdata,
    output logic [CAL_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    logic             allow_all;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             stall;
    logic             plen_ok;
    logic             room;
    logic             do_write;
    logic             drop;
    logic             chk;
    cal_addr_t        mask;
    cal_wr_t          wr;

    logic             valid_chain [MAX_ENTRIES+1];
    cal_beat_t        beat_chain  [MAX_ENTRIES+1];
    logic [CNT_W-1:0] limit_chain [MAX_ENTRIES+1];

    cal_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .allow_all (allow_all)
    );

    // Handshake: the chain only moves when the last cell can hand off its beat
    assign stall      = valid_chain[MAX_ENTRIES] & ~result.ready;
    assign item.ready = ~stall;
    assign accept     = item.valid & item.ready;

    assign plen_ok = item.prefix_length <= PLEN_MAX;
    assign room    = cnt_reg < CNT_W'(MAX_ENTRIES);
    assign mask    = prefix_mask(item.prefix_length);

    // Kind decode and entry count update
    always_comb
    begin
        do_write = 1'b0;
        drop     = 1'b0;
        chk      = 1'b0;
        cnt_next = cnt_reg;
        if (accept)
        begin
            unique case (item.kind)
                KIND_ADD:
                begin
                    if (plen_ok)
                    begin
                        if (room)
                        begin
                            do_write = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            drop = 1'b1;
                        end
                    end
                end
                KIND_CHECK: chk = 1'b1;
                KIND_CLEAR: cnt_next = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Entry write data, broadcast to all cells
    assign wr.network = item.address & mask;
    assign wr.mask    = mask;

    // Head of the chain
    assign valid_chain[0]     = accept;
    assign beat_chain[0].chk  = chk;
    assign beat_chain[0].hit  = chk & allow_all;
    assign beat_chain[0].drop = drop;
    assign beat_chain[0].addr = item.address;
    assign limit_chain[0]     = cnt_reg;

    // Row of cells
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        cal_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (~stall),
            .wr_en     (do_write && (cnt_reg == CNT_W'(i))),
            .wr        (wr),
            .valid_in  (valid_chain[i]),
            .beat_in   (beat_chain[i]),
            .limit_in  (limit_chain[i]),
            .valid_out (valid_chain[i+1]),
            .beat_out  (beat_chain[i+1]),
            .limit_out (limit_chain[i+1])
        );
    end

    // Tail of the chain is the result register
    assign result.valid   = valid_chain[MAX_ENTRIES];
    assign result.allowed = beat_chain[MAX_ENTRIES].hit;
    assign result.dropped = beat_chain[MAX_ENTRIES].drop;

    // Checks
    `CAL_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_ENTRIES))
    `CAL_ASSERT_SAME(a_one_flag, result.valid, !(result.allowed && result.dropped))
    `CAL_ASSERT_NEXT(a_clear_empties, accept && (item.kind == KIND_CLEAR), cnt_reg == '0)
    `CAL_ASSERT_NEXT(a_add_grows, do_write, cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule
